>>> src/utf8s_pkg.sv
// Package for the UTF-8 sanitizer: shared constants, the result-run type
// and decode helpers. No dependencies.
package utf8s_pkg;

   localparam int          RunMax     = 4;
   localparam int          HeldDepth  = 3;
   localparam logic [7:0]  SpaceChar  = 8'h20;
   localparam logic [10:0] Min2Byte   = 11'h080;
   localparam logic [15:0] Min3Byte   = 16'h0800;
   localparam logic [20:0] Min4Byte   = 21'h010000;
   localparam logic [20:0] Max4Byte   = 21'h10ffff;

   // Results caused by one input transaction, in emit order.
   typedef struct packed {
      logic                    valid;
      logic [RunMax-1:0][7:0]  bytes;
      logic [RunMax-1:0]       repl;
      logic [1:0]              last_idx;
      logic                    string_end;
      logic                    had_invalid;
   } run_type;

   // Expected sequence length for a lead byte, 0 if not a multi-byte lead.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if ((b & 8'he0) == 8'hc0) begin
         len = 3'd2;
      end else if ((b & 8'hf0) == 8'he0) begin
         len = 3'd3;
      end else if ((b & 8'hf8) == 8'hf0) begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

>>> src/utf8s_if.sv
// Valid/ready channel interfaces for byte transactions in and repaired
// bytes out. No dependencies.
interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface utf8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       was_replaced;
   logic       end_of_string;
   logic       string_had_invalid;
   logic       last_of_run;

   modport source (output valid, output out_byte, output was_replaced,
                   output end_of_string, output string_had_invalid,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input was_replaced,
                   input end_of_string, input string_had_invalid,
                   input last_of_run, output ready);
endinterface

>>> src/utf8_sanitizer_core.sv
// UTF-8 sanitizer top level: sequence tracker feeding the run buffer and
// output register. Depends on utf8s_pkg, utf8s_if, utf8s_scan, utf8s_emit.
//
// Usage: bytes of a string enter on req_bus, one per transaction, with
// string_end set on the last byte. Repaired bytes leave on rsp_bus; invalid
// or cut-short sequences come out as spaces with was_replaced set. A lead
// byte and its continuation bytes are held (no result) until the sequence
// completes or breaks, then released as a burst of up to four results.
// last_of_run marks the final result of an input transaction; on a
// string_end input it also carries end_of_string and string_had_invalid.
// A result is registered in the run buffer and then in the output register.
// Throughput: one transaction per cycle while each causes at most one result
// and rsp_bus does not stall; an input releasing several results holds
// req_bus while the single output register drains the run buffer. A stalled
// rsp_bus holds its payload; the run buffer then fills and req_bus.ready
// drops. Reset clears held state and empties both stages.
module utf8_sanitizer_core (
   input  logic        clock,
   input  logic        reset,
   utf8s_req_if.sink   req_bus,
   utf8s_rsp_if.source rsp_bus
);
   import utf8s_pkg::*;

   run_type run;
   logic    run_ready;
   logic    req_accept;

   assign req_bus.ready = run_ready;
   assign req_accept    = req_bus.valid && run_ready;

   utf8s_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .in_byte    (req_bus.in_byte),
      .string_end (req_bus.string_end),
      .run        (run)
   );

   utf8s_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .run_in    (run),
      .run_load  (req_accept),
      .run_ready (run_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

>>> src/utf8s_scan.sv
// Sequence tracker: holds lead and continuation bytes and builds the run of
// results for each accepted transaction. Depends on utf8s_pkg.
module utf8s_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              string_end,
   output utf8s_pkg::run_type run
);
   import utf8s_pkg::*;

   logic [7:0] held_ff [HeldDepth];
   logic [1:0] held_count_ff, held_count_in;
   logic [2:0] seq_len_ff, seq_len_in;
   logic       invalid_ff, invalid_in;

   logic [2:0] len;
   logic       is_cont;
   logic       fresh_emit, fresh_repl, fresh_start;
   logic [1:0] flush_cnt;
   logic       flush_repl, emit_b, b_repl, start, extend, ok;
   logic [2:0] count;
   logic [7:0] b_out;
   logic [5:0] c1, c2, c3;
   logic [10:0] v2;
   logic [15:0] v3;
   logic [20:0] v4;

   // Range check of a sequence completed by in_byte.
   always_comb begin
      c3 = in_byte[5:0];
      c1 = (held_count_ff >= 2'd2) ? held_ff[1][5:0] : c3;
      c2 = (held_count_ff >= 2'd3) ? held_ff[2][5:0] : c3;
      v2 = {held_ff[0][4:0], c3};
      v3 = {held_ff[0][3:0], c1, c3};
      v4 = {held_ff[0][2:0], c1, c2, c3};
      case (seq_len_ff)
         3'd2:    ok = (v2 >= Min2Byte);
         3'd3:    ok = (v3 >= Min3Byte);
         default: ok = (v4 >= Min4Byte) && (v4 <= Max4Byte);
      endcase
   end

   always_comb begin
      len     = lead_len(in_byte);
      is_cont = (in_byte[7:6] == 2'b10);

      fresh_emit  = 1'b0;
      fresh_repl  = 1'b0;
      fresh_start = 1'b0;
      if (!in_byte[7]) begin
         fresh_emit = 1'b1;
      end else if (len == 3'd0 || string_end) begin
         fresh_emit = 1'b1;
         fresh_repl = 1'b1;
      end else begin
         fresh_start = 1'b1;
      end

      flush_cnt  = 2'd0;
      flush_repl = 1'b0;
      emit_b     = 1'b0;
      b_repl     = 1'b0;
      start      = 1'b0;
      extend     = 1'b0;
      if (seq_len_ff == 3'd0 || held_count_ff == 2'd0) begin
         emit_b = fresh_emit;
         b_repl = fresh_repl;
         start  = fresh_start;
      end else if (is_cont) begin
         if ({1'b0, held_count_ff} + 3'd1 >= seq_len_ff) begin
            flush_cnt  = held_count_ff;
            flush_repl = !ok;
            emit_b     = 1'b1;
            b_repl     = !ok;
         end else if (string_end || held_count_ff == 2'd3) begin
            flush_cnt  = held_count_ff;
            flush_repl = 1'b1;
            emit_b     = 1'b1;
            b_repl     = 1'b1;
         end else begin
            extend = 1'b1;
         end
      end else begin
         // interrupted sequence: held bytes become spaces, new byte rescanned
         flush_cnt  = held_count_ff;
         flush_repl = 1'b1;
         emit_b     = fresh_emit;
         b_repl     = fresh_repl;
         start      = fresh_start;
      end

      b_out = b_repl ? SpaceChar : in_byte;
      count = {1'b0, flush_cnt} + {2'b00, emit_b};

      for (int i = 0; i < HeldDepth; i++) begin
         if (2'(i) < flush_cnt) begin
            run.bytes[i] = flush_repl ? SpaceChar : held_ff[i];
            run.repl[i]  = flush_repl;
         end else begin
            run.bytes[i] = b_out;
            run.repl[i]  = b_repl;
         end
      end
      run.bytes[RunMax-1] = b_out;
      run.repl[RunMax-1]  = b_repl;
      run.valid           = (count != 3'd0);
      run.last_idx        = 2'(count - 3'd1);
      run.string_end      = string_end;
      run.had_invalid     = invalid_ff || (flush_cnt != 2'd0 && flush_repl)
                            || (emit_b && b_repl);

      held_count_in = 2'd0;
      seq_len_in    = 3'd0;
      if (extend) begin
         held_count_in = held_count_ff + 2'd1;
         seq_len_in    = seq_len_ff;
      end else if (start) begin
         held_count_in = 2'd1;
         seq_len_in    = len;
      end
      invalid_in = string_end ? 1'b0 : run.had_invalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         seq_len_ff    <= 3'd0;
         invalid_ff    <= 1'b0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         seq_len_ff    <= seq_len_in;
         invalid_ff    <= invalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && start) begin
         held_ff[0] <= in_byte;
      end else if (accept && extend) begin
         held_ff[held_count_ff] <= in_byte;
      end
   end

endmodule

>>> src/utf8s_emit.sv
// Run buffer and output register: emits one repaired byte per cycle from the
// current run unless rsp_bus stalls. Depends on utf8s_pkg and utf8s_rsp_if.
module utf8s_emit (
   input  logic               clock,
   input  logic               reset,
   input  utf8s_pkg::run_type run_in,
   input  logic               run_load,
   output logic               run_ready,
   utf8s_rsp_if.source        rsp_bus
);
   import utf8s_pkg::*;

   run_type    buf_ff, buf_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_repl_ff, out_repl_in;
   logic       out_end_ff, out_end_in;
   logic       out_inv_ff, out_inv_in;
   logic       out_last_ff, out_last_in;

   logic out_free, buf_last, load_out;

   always_comb begin
      out_free  = !out_valid_ff || rsp_bus.ready;
      buf_last  = buf_ff.valid && (idx_ff == buf_ff.last_idx);
      load_out  = buf_ff.valid && out_free;
      run_ready = !buf_ff.valid || (load_out && buf_last);

      buf_in       = buf_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_byte_in  = out_byte_ff;
      out_repl_in  = out_repl_ff;
      out_end_in   = out_end_ff;
      out_inv_in   = out_inv_ff;
      out_last_in  = out_last_ff;

      if (load_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = buf_ff.bytes[idx_ff];
         out_repl_in  = buf_ff.repl[idx_ff];
         out_last_in  = buf_last;
         out_end_in   = buf_last && buf_ff.string_end;
         out_inv_in   = buf_last && buf_ff.string_end && buf_ff.had_invalid;
         idx_in       = buf_last ? 2'd0 : idx_ff + 2'd1;
      end
      if (run_ready) begin
         buf_in       = run_in;
         buf_in.valid = run_load && run_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff.valid <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff        <= out_byte_in;
      out_repl_ff        <= out_repl_in;
      out_end_ff         <= out_end_in;
      out_inv_ff         <= out_inv_in;
      out_last_ff        <= out_last_in;
   end

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.out_byte           = out_byte_ff;
   assign rsp_bus.was_replaced       = out_repl_ff;
   assign rsp_bus.end_of_string      = out_end_ff;
   assign rsp_bus.string_had_invalid = out_inv_ff;
   assign rsp_bus.last_of_run        = out_last_ff;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for utf8_sanitizer_core: directed and random byte
// strings, checked result by result against an internal repair predictor.
// Depends on utf8s_pkg, utf8s_if and the sanitizer RTL.
module tb_top;
   import utf8s_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       was_replaced;
      logic       end_of_string;
      logic       string_had_invalid;
      logic       last_of_run;
   } repair_type;

   logic clock = 1'b0;
   logic reset;

   utf8s_req_if req_bus();
   utf8s_rsp_if rsp_bus();

   utf8_sanitizer_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0] held [3];
   logic [1:0] held_cnt;
   logic [2:0] seq_len;
   logic       inv_seen;
   repair_type run_q [$];
   repair_type repaired_q [$];

   logic [7:0] str_q [$];
   bit         quiet;
   int         stall_left;
   int         errs;
   int         n_bytes;
   int         n_strings;
   int         n_results;
   int         n_spaces;

   function automatic void add_out(input logic [7:0] b, input logic repl);
      repair_type r;
      r = '0;
      r.out_byte = repl ? SpaceChar : b;
      r.was_replaced = repl;
      if (repl) begin
         inv_seen = 1'b1;
      end
      run_q.push_back(r);
   endfunction

   function automatic void flush_held(input logic repl);
      for (int i = 0; i < int'(held_cnt); i++) begin
         add_out(held[i], repl);
      end
      held_cnt = '0;
      seq_len = '0;
   endfunction

   function automatic void scan_fresh(input logic [7:0] b, input logic fin);
      logic [2:0] len;
      len = '0;
      if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end
      if (!b[7]) begin
         add_out(b, 1'b0);
      end else if (len == 0 || fin) begin
         add_out(b, 1'b1);
      end else begin
         held[0] = b;
         held_cnt = 2'd1;
         seq_len = len;
      end
   endfunction

   function automatic logic code_in_range(input logic [7:0] last);
      logic [5:0]  c1;
      logic [5:0]  c2;
      logic [20:0] cp;
      c1 = (held_cnt >= 2) ? held[1][5:0] : last[5:0];
      c2 = (held_cnt >= 3) ? held[2][5:0] : last[5:0];
      if (seq_len == 3'd2) begin
         cp = {10'd0, held[0][4:0], last[5:0]};
         return cp >= 21'(Min2Byte) && cp <= 21'h7ff;
      end else if (seq_len == 3'd3) begin
         cp = {5'd0, held[0][3:0], c1, last[5:0]};
         return cp >= 21'(Min3Byte);
      end
      cp = {held[0][2:0], c1, c2, last[5:0]};
      return cp >= Min4Byte && cp <= Max4Byte;
   endfunction

   function automatic void predict_repair(input logic [7:0] b, input logic fin);
      logic ok;
      int   last;
      run_q.delete();
      if (seq_len == 0 || held_cnt == 0) begin
         held_cnt = '0;
         seq_len = '0;
         scan_fresh(b, fin);
      end else if (b[7:6] == 2'b10) begin
         if (int'(held_cnt) + 1 >= int'(seq_len)) begin
            ok = code_in_range(b);
            flush_held(!ok);
            add_out(b, !ok);
         end else if (fin || held_cnt >= 3) begin
            flush_held(1'b1);
            add_out(b, 1'b1);
         end else begin
            held[held_cnt] = b;
            held_cnt = held_cnt + 2'd1;
         end
      end else begin
         flush_held(1'b1);
         scan_fresh(b, fin);
      end
      if (run_q.size() > 0) begin
         last = run_q.size() - 1;
         run_q[last].last_of_run = 1'b1;
         if (fin) begin
            run_q[last].end_of_string = 1'b1;
            run_q[last].string_had_invalid = inv_seen;
         end
      end
      if (fin) begin
         inv_seen = 1'b0;
         held_cnt = '0;
         seq_len = '0;
      end
      foreach (run_q[i]) begin
         repaired_q.push_back(run_q[i]);
      end
   endfunction

   function automatic void flag_error(input string msg);
      errs++;
      if (errs <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      repair_type got;
      repair_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.out_byte = rsp_bus.out_byte;
         got.was_replaced = rsp_bus.was_replaced;
         got.end_of_string = rsp_bus.end_of_string;
         got.string_had_invalid = rsp_bus.string_had_invalid;
         got.last_of_run = rsp_bus.last_of_run;
         n_results++;
         if (got.was_replaced) begin
            n_spaces++;
         end
         if (repaired_q.size() == 0) begin
            flag_error($sformatf("unexpected result byte=%02h repl=%b eos=%b inv=%b last=%b",
               got.out_byte, got.was_replaced, got.end_of_string,
               got.string_had_invalid, got.last_of_run));
         end else begin
            want = repaired_q.pop_front();
            if (got !== want) begin
               flag_error($sformatf({"exp byte=%02h repl=%b eos=%b inv=%b last=%b, ",
                  "got byte=%02h repl=%b eos=%b inv=%b last=%b"},
                  want.out_byte, want.was_replaced, want.end_of_string,
                  want.string_had_invalid, want.last_of_run,
                  got.out_byte, got.was_replaced, got.end_of_string,
                  got.string_had_invalid, got.last_of_run));
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.string_end <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_repair(b, fin);
      n_bytes++;
   endtask

   task automatic send_str();
      foreach (str_q[i]) begin
         send_byte(str_q[i], i == str_q.size() - 1);
      end
      str_q.delete();
      n_strings++;
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (repaired_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_stray_bytes();
      // ASCII extremes, stray continuation, 0xF8..0xFF, lone lead at end
      str_q = '{8'h00, 8'h7f, 8'h80, 8'hf8, 8'hff, 8'hc3};
      send_str();
   endtask

   task automatic test_valid_sequences();
      // smallest 2-byte, surrogate, largest 4-byte
      str_q = '{8'hc2, 8'h80, 8'hed, 8'hbf, 8'hbf, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
      send_str();
   endtask

   task automatic test_out_of_range();
      // overlong 2- and 3-byte, above U+10FFFF
      str_q = '{8'hc1, 8'hbf, 8'he0, 8'h9f, 8'hbf, 8'hf4, 8'h90, 8'h80, 8'h80};
      send_str();
   endtask

   task automatic test_broken_sequences();
      // interrupted by a new lead, then a held lead cut short at the end
      str_q = '{8'he2, 8'h82, 8'hc3, 8'ha9, 8'hf0, 8'h90};
      send_str();
   endtask

   task automatic add_char();
      int          pick;
      logic [20:0] cp;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         str_q.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 45) begin
         cp = 21'($urandom_range('h80, 'h7ff));
         str_q.push_back({3'b110, cp[10:6]});
         str_q.push_back({2'b10, cp[5:0]});
      end else if (pick < 60) begin
         cp = 21'($urandom_range('h800, 'hffff));
         str_q.push_back({4'b1110, cp[15:12]});
         str_q.push_back({2'b10, cp[11:6]});
         str_q.push_back({2'b10, cp[5:0]});
      end else if (pick < 75) begin
         cp = 21'($urandom_range('h10000, 'h10ffff));
         str_q.push_back({5'b11110, cp[20:18]});
         str_q.push_back({2'b10, cp[17:12]});
         str_q.push_back({2'b10, cp[11:6]});
         str_q.push_back({2'b10, cp[5:0]});
      end else if (pick < 88) begin
         str_q.push_back(8'($urandom_range('hc0, 'hf7)));
         repeat ($urandom_range(0, 3)) str_q.push_back({2'b10, 6'($urandom)});
      end else begin
         str_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_strings();
      int first;
      first = n_bytes;
      while (n_bytes - first < 140) begin
         repeat ($urandom_range(1, 5)) add_char();
         if (n_bytes - first > 105) begin
            quiet = 1'b1;
         end else if ($urandom_range(0, 19) == 0) begin
            wait_drain();
         end
         send_str();
      end
   endtask

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      req_bus.string_end = 1'b0;
      rsp_bus.ready = 1'b0;
      held_cnt = '0;
      seq_len = '0;
      inv_seen = 1'b0;
      quiet = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stray_bytes();
      test_valid_sequences();
      test_out_of_range();
      test_broken_sequences();
      wait_drain();
      test_random_strings();

      wait_drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes in %0d strings (valid, overlong, broken, stray, noise);",
         n_bytes, n_strings);
      $display("checked %0d repaired bytes, %0d of them spaces.", n_results, n_spaces);
      if (errs == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
src/utf8s_pkg.sv
src/utf8s_if.sv
src/utf8s_scan.sv
src/utf8s_emit.sv
src/utf8_sanitizer_core.sv
tb/tb_top.sv
